// ----- rtl/max_filter_3x3_assert.svh -----
// Assertion macros for the 3x3 max filter.
`ifndef MAX_FILTER_3X3_ASSERT_SVH
`define MAX_FILTER_3X3_ASSERT_SVH

// Property checked on every rising edge of clk outside reset.
`define MF3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Condition that must never hold.
`define MF3_NEVER(lbl, cond, msg) \
  `MF3_ASSERT(lbl, !(cond), msg)

`endif

// ----- rtl/mf3_pkg.sv -----
// Shared types, constants and helpers for the 3x3 max filter.
package mf3_pkg;

  localparam int MAX_SIDE_DEF = 1024;
  localparam int SIDE_MIN     = 3;
  localparam int PIX_W        = 8;
  localparam int CFG_W        = 11;
  localparam int APB_DW       = 32;
  localparam int APB_AW       = 3;

  localparam logic [CFG_W-1:0] SIDE_RESET     = CFG_W'(1024);
  localparam logic [0:0]       REG_IMAGE_SIDE = 1'b0;

  typedef logic [PIX_W-1:0] pix_t;

  // Per-pixel position flags, carried with the pixel into the compute stage.
  typedef struct packed {
    logic r_ge1;
    logic r_ge2;
    logic emit;
    logic last;
  } mf3_ctl_t;

  function automatic pix_t mf3_max8(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- rtl/mf3_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/mf3_window.sv -----
// Compute stage: column max, two-column history, window max and result register.
module mf3_window import mf3_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear,
  input  logic                        take,
  input  pix_t                        take_pix,
  input  logic [$clog2(MAX_SIDE)-1:0] take_col,
  input  mf3_ctl_t                    take_ctl,
  input  pix_t                        up_rd,
  input  pix_t                        mid_rd,
  output logic                        busy,
  output logic                        wr_en,
  output logic [$clog2(MAX_SIDE)-1:0] wr_addr,
  output pix_t                        up_wdata,
  output pix_t                        mid_wdata,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pix_t                        window_max,
  output logic                        frame_last
);

  localparam int AW = $clog2(MAX_SIDE);

  logic          s1_valid;
  pix_t          s1_pix;
  logic [AW-1:0] s1_col;
  mf3_ctl_t      s1_ctl;
  logic          s1_go;
  pix_t          hist0;
  pix_t          hist1;
  pix_t          up;
  pix_t          mid;
  pix_t          colmax;
  pix_t          win;

  assign s1_go = s1_valid && (!s1_ctl.emit || !out_valid || !out_stall);
  assign busy  = s1_valid && !s1_go;

  assign up     = s1_ctl.r_ge2 ? up_rd : '0;
  assign mid    = s1_ctl.r_ge1 ? mid_rd : '0;
  assign colmax = mf3_max8(mf3_max8(up, mid), s1_pix);
  assign win    = mf3_max8(colmax, mf3_max8(hist0, hist1));

  assign wr_en     = s1_go;
  assign wr_addr   = s1_col;
  assign up_wdata  = mid;
  assign mid_wdata = s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pix <= take_pix;
      s1_col <= take_col;
      s1_ctl <= take_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      hist0 <= '0;
      hist1 <= '0;
    end else if (s1_go) begin
      hist1 <= hist0;
      hist0 <= colmax;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_ctl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_ctl.emit) begin
      window_max <= win;
      frame_last <= s1_ctl.last;
    end
  end

endmodule

// ----- rtl/max_filter_3x3.sv -----
// Top level of the streaming 3x3 max filter.
// Path: an accepted pixel is registered in the compute stage, and its result then in the output register;
//   a stalled result can hold the pixel in the compute stage before its result is registered.
// Throughput: one pixel per cycle while results are taken; a stalled result blocks input.
// Results: (n-2)^2 per frame, frame_last on the final one.
// Reset: clears counters, column history and valid flags; line stores are not cleared.
module max_filter_3x3 import mf3_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIX_W-1:0]  pixel_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PIX_W-1:0]  window_max,
  output logic              frame_last
);

  `include "max_filter_3x3_assert.svh"

  localparam int AW = $clog2(MAX_SIDE);
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int CW = (SW > CFG_W) ? SW : CFG_W;

  logic [CFG_W-1:0] image_side;
  logic             cfg_wr;
  logic [CW-1:0]    side_ext;
  logic [SW-1:0]    side_use;
  logic [AW-1:0]    side_m1;
  logic [AW-1:0]    row_pos;
  logic [AW-1:0]    col_pos;
  logic [AW-1:0]    row_next;
  logic [AW-1:0]    col_next;
  logic             accept;
  logic             busy;
  mf3_ctl_t         ctl;
  pix_t             up_rd;
  pix_t             mid_rd;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  pix_t             up_wdata;
  pix_t             mid_wdata;
  logic             pos_ok;
  logic             wrap_pt;
  logic             at_origin;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_IMAGE_SIDE);

  always_comb begin
    prdata = '0;
    if (paddr[2:2] == REG_IMAGE_SIDE) begin
      prdata = APB_DW'(image_side);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_side <= SIDE_RESET;
    end else if (cfg_wr) begin
      image_side <= pwdata[CFG_W-1:0];
    end
  end

  // Side clamped to the supported range
  always_comb begin
    side_ext = CW'(image_side);
    if (side_ext < CW'(SIDE_MIN)) begin
      side_use = SW'(SIDE_MIN);
    end else if (side_ext > CW'(MAX_SIDE)) begin
      side_use = SW'(MAX_SIDE);
    end else begin
      side_use = side_ext[SW-1:0];
    end
  end

  assign side_m1 = AW'(side_use - SW'(1));

  // Position counters
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    row_next = row_pos;
    col_next = col_pos + AW'(1);
    if (col_pos == side_m1) begin
      col_next = '0;
      row_next = (row_pos == side_m1) ? '0 : row_pos + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      row_pos <= row_next;
      col_pos <= col_next;
    end
  end

  assign ctl.r_ge1 = (row_pos >= AW'(1));
  assign ctl.r_ge2 = (row_pos >= AW'(2));
  assign ctl.emit  = ctl.r_ge2 && (col_pos >= AW'(2));
  assign ctl.last  = (row_pos == side_m1) && (col_pos == side_m1);

  // Line stores
  mf3_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_SIDE)
  ) u_upper (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(up_wdata),
    .re   (accept),
    .raddr(col_pos),
    .rdata(up_rd)
  );

  mf3_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_SIDE)
  ) u_middle (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(mid_wdata),
    .re   (accept),
    .raddr(col_pos),
    .rdata(mid_rd)
  );

  mf3_window #(
    .MAX_SIDE(MAX_SIDE)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_wr),
    .take      (accept),
    .take_pix  (pixel_value),
    .take_col  (col_pos),
    .take_ctl  (ctl),
    .up_rd     (up_rd),
    .mid_rd    (mid_rd),
    .busy      (busy),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .up_wdata  (up_wdata),
    .mid_wdata (mid_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .window_max(window_max),
    .frame_last(frame_last)
  );

  // Checks
  assign pos_ok    = (SW'(row_pos) < side_use) && (SW'(col_pos) < side_use);
  assign wrap_pt   = accept && !cfg_wr && ctl.last;
  assign at_origin = (row_pos == '0) && (col_pos == '0);

  `MF3_ASSERT(a_pos_in_range, pos_ok, "position beyond side")
  `MF3_ASSERT(a_frame_wrap, wrap_pt |=> at_origin, "frame did not wrap")
  `MF3_NEVER(a_last_needs_emit, ctl.last && !ctl.emit, "last pixel without result")

endmodule
